@@ rtl/rrcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcm_pkg
// Shared constants for the rotated rectangle clip mapper: panel size
// defaults, command / driver operation codes and register map.
// ----------------------------------------------------------------------------
package rrcm_pkg;

   // default native panel size in pixels
   localparam int unsigned NATIVE_WIDTH_DEF  = 96;
   localparam int unsigned NATIVE_HEIGHT_DEF = 64;

   // command codes (input) and driver operation codes (output)
   localparam logic [1:0] OP_PIXEL  = 2'd0;
   localparam logic [1:0] OP_RECT   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // register map: word index taken from paddr[2]
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        REG_ROTATION = 1'b0;

endpackage

@@ rtl/rotated_rect_clip_mapper_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rect_clip_mapper_top
// Maps pixel, filled-rectangle and clear commands from rotated logical
// coordinates to native panel operations, clipping to the screen.
//
// Usage:
//   req_* : one drawing command per transaction (valid/ready).
//   rsp_* : zero or one driver operation per command (valid/ready);
//           off-screen pixels, empty or fully clipped rectangles and the
//           unused command code produce no response.
//   csr_* : APB-style port, one register (rotation, byte address 0).
//           Change rotation only while no command is in flight.
//   Path: an accepted command passes the clamp, clip and map stages in
//   order; the map stage is the output register that drives rsp_*.
//   Throughput: one command per cycle through three stages unless stalled.
//   Reset: synchronous; rotation returns to 0, all stages empty.
//   Stall: when rsp_ready is low the output holds, the stages behind it
//   fill, and req_ready drops once all three stages hold a transaction.
// ----------------------------------------------------------------------------
module rotated_rect_clip_mapper_top #(
   parameter int unsigned NATIVE_WIDTH  = rrcm_pkg::NATIVE_WIDTH_DEF,
   parameter int unsigned NATIVE_HEIGHT = rrcm_pkg::NATIVE_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rrcm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   // command channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_cmd,
   input  logic [15:0]                     req_pos_x,
   input  logic [15:0]                     req_pos_y,
   input  logic [15:0]                     req_rect_w,
   input  logic [15:0]                     req_rect_h,
   input  logic [15:0]                     req_color,
   // driver operation channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_op,
   output logic [7:0]                      rsp_native_x,
   output logic [7:0]                      rsp_native_y,
   output logic [7:0]                      rsp_native_w,
   output logic [7:0]                      rsp_native_h,
   output logic [15:0]                     rsp_out_color
);

   logic [1:0] rotation_ff, rotation_in;
   logic       reg_sel;

   // register decode: word index in paddr[2]
   assign reg_sel    = (csr_paddr[2] == rrcm_pkg::REG_ROTATION);
   assign csr_pready = 1'b1;

   always_comb begin
      rotation_in = rotation_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         rotation_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= 2'd0;
      end else begin
         rotation_ff <= rotation_in;
      end
   end

   // read back
   assign csr_prdata = reg_sel ? {30'd0, rotation_ff} : 32'd0;

   rrcm_pipe #(
      .NATIVE_WIDTH  (NATIVE_WIDTH),
      .NATIVE_HEIGHT (NATIVE_HEIGHT)
   ) u_pipe (
      .clock         (clock),
      .reset         (reset),
      .rotation      (rotation_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_rect_w    (req_rect_w),
      .req_rect_h    (req_rect_h),
      .req_color     (req_color),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_op        (rsp_op),
      .rsp_native_x  (rsp_native_x),
      .rsp_native_y  (rsp_native_y),
      .rsp_native_w  (rsp_native_w),
      .rsp_native_h  (rsp_native_h),
      .rsp_out_color (rsp_out_color)
   );

endmodule

@@ rtl/rrcm_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcm_pipe
// Three-stage datapath: origin clamp, screen clip, native mapping.
// Each stage holds a valid bit; a stage loads when it is empty or when its
// content moves on, so a stalled output holds the run of full stages behind it.
// ----------------------------------------------------------------------------
module rrcm_pipe #(
   parameter int unsigned NATIVE_WIDTH  = rrcm_pkg::NATIVE_WIDTH_DEF,
   parameter int unsigned NATIVE_HEIGHT = rrcm_pkg::NATIVE_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  rotation,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_rect_w,
   input  logic [15:0] req_rect_h,
   input  logic [15:0] req_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_op,
   output logic [7:0]  rsp_native_x,
   output logic [7:0]  rsp_native_y,
   output logic [7:0]  rsp_native_w,
   output logic [7:0]  rsp_native_h,
   output logic [15:0] rsp_out_color
);

   localparam logic [7:0] NW = 8'(NATIVE_WIDTH);
   localparam logic [7:0] NH = 8'(NATIVE_HEIGHT);

   // stage 1: clamped origin and shrunk size
   typedef struct packed {
      logic [1:0]         op;
      logic [14:0]        x;
      logic [14:0]        y;
      logic signed [16:0] w;
      logic signed [16:0] h;
      logic [15:0]        color;
   } s1_type;

   // stage 2: clipped rectangle on the logical screen
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [15:0] color;
   } s2_type;

   logic   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic   rdy1, rdy2, rdy3;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s2_type s3_ff, s3_in;

   // logical screen size follows rotation parity
   logic [7:0] lw, lh;
   assign lw = rotation[0] ? NH : NW;
   assign lh = rotation[0] ? NW : NH;

   // stall chain: a stage takes new data when empty or draining
   assign rdy3      = !v3_ff || rsp_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   // ---- stage 1 logic: pixel becomes a 1x1 rect, clamp negative origin ----
   logic signed [16:0] in_w, in_h, x_ext, y_ext;
   always_comb begin
      in_w  = (req_cmd == rrcm_pkg::OP_PIXEL) ? 17'sd1 : {req_rect_w[15], req_rect_w};
      in_h  = (req_cmd == rrcm_pkg::OP_PIXEL) ? 17'sd1 : {req_rect_h[15], req_rect_h};
      x_ext = {req_pos_x[15], req_pos_x};
      y_ext = {req_pos_y[15], req_pos_y};
      s1_in.op    = req_cmd;
      s1_in.color = req_color;
      s1_in.x     = req_pos_x[15] ? 15'd0 : req_pos_x[14:0];
      s1_in.y     = req_pos_y[15] ? 15'd0 : req_pos_y[14:0];
      s1_in.w     = req_pos_x[15] ? in_w + x_ext : in_w;
      s1_in.h     = req_pos_y[15] ? in_h + y_ext : in_h;
      v1_in       = req_valid && (req_cmd != rrcm_pkg::OP_UNUSED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
   end

   // ---- stage 2 logic: screen bounds and right/bottom clip ----
   logic signed [17:0] end_x, end_y, lw_s, lh_s;
   logic               on_x, on_y, w_pos, h_pos, keep2;
   always_comb begin
      end_x = $signed({3'b000, s1_ff.x}) + $signed({s1_ff.w[16], s1_ff.w});
      end_y = $signed({3'b000, s1_ff.y}) + $signed({s1_ff.h[16], s1_ff.h});
      lw_s  = $signed({10'd0, lw});
      lh_s  = $signed({10'd0, lh});
      on_x  = s1_ff.x < {7'd0, lw};
      on_y  = s1_ff.y < {7'd0, lh};
      w_pos = !s1_ff.w[16] && (s1_ff.w != 17'sd0);
      h_pos = !s1_ff.h[16] && (s1_ff.h != 17'sd0);
      keep2 = (s1_ff.op == rrcm_pkg::OP_CLEAR) || (on_x && on_y && w_pos && h_pos);
      s2_in.op    = s1_ff.op;
      s2_in.color = s1_ff.color;
      s2_in.x     = s1_ff.x[7:0];
      s2_in.y     = s1_ff.y[7:0];
      s2_in.w     = (end_x > lw_s) ? lw - s1_ff.x[7:0] : s1_ff.w[7:0];
      s2_in.h     = (end_y > lh_s) ? lh - s1_ff.y[7:0] : s1_ff.h[7:0];
      v2_in       = v1_ff && keep2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_ff <= s2_in;
      end
   end

   // ---- stage 3 logic: rotate into native frame ----
   // far corner maps to the native origin on mirrored axes, so the sorted
   // origin is size minus origin minus extent; odd rotations swap extents
   logic [8:0] far_w_y, far_w_x, far_h_y, far_h_x;
   always_comb begin
      far_w_y = {1'b0, NW} - {1'b0, s2_ff.y} - {1'b0, s2_ff.h};
      far_w_x = {1'b0, NW} - {1'b0, s2_ff.x} - {1'b0, s2_ff.w};
      far_h_y = {1'b0, NH} - {1'b0, s2_ff.y} - {1'b0, s2_ff.h};
      far_h_x = {1'b0, NH} - {1'b0, s2_ff.x} - {1'b0, s2_ff.w};
      s3_in.op    = s2_ff.op;
      s3_in.color = s2_ff.color;
      case (rotation)
         2'd1: begin
            s3_in.x = far_w_y[7:0];
            s3_in.y = s2_ff.x;
            s3_in.w = s2_ff.h;
            s3_in.h = s2_ff.w;
         end
         2'd2: begin
            s3_in.x = far_w_x[7:0];
            s3_in.y = far_h_y[7:0];
            s3_in.w = s2_ff.w;
            s3_in.h = s2_ff.h;
         end
         2'd3: begin
            s3_in.x = s2_ff.y;
            s3_in.y = far_h_x[7:0];
            s3_in.w = s2_ff.h;
            s3_in.h = s2_ff.w;
         end
         default: begin
            s3_in.x = s2_ff.x;
            s3_in.y = s2_ff.y;
            s3_in.w = s2_ff.w;
            s3_in.h = s2_ff.h;
         end
      endcase
      // clear carries no geometry
      if (s2_ff.op == rrcm_pkg::OP_CLEAR) begin
         s3_in.x = 8'd0;
         s3_in.y = 8'd0;
         s3_in.w = 8'd0;
         s3_in.h = 8'd0;
      end
      v3_in = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   // output register drives the response channel
   assign rsp_valid     = v3_ff;
   assign rsp_op        = s3_ff.op;
   assign rsp_native_x  = s3_ff.x;
   assign rsp_native_y  = s3_ff.y;
   assign rsp_native_w  = s3_ff.w;
   assign rsp_native_h  = s3_ff.h;
   assign rsp_out_color = s3_ff.color;

endmodule

@@ rtl/rrcm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcm_checker
// Port-level checks on the driver operation channel, bound to the top level.
// ----------------------------------------------------------------------------
module rrcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_op,
   input logic [7:0]  rsp_native_x,
   input logic [7:0]  rsp_native_y,
   input logic [7:0]  rsp_native_w,
   input logic [7:0]  rsp_native_h,
   input logic [15:0] rsp_out_color
);

   // stalled transaction stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // stalled transaction keeps its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_op) && $stable(rsp_native_x) &&
      $stable(rsp_native_y) && $stable(rsp_native_w) && $stable(rsp_native_h) &&
      $stable(rsp_out_color))
      else $error("rsp payload changed while stalled");

   // the unused command never reaches the driver
   a_no_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_op != rrcm_pkg::OP_UNUSED)
      else $error("unused operation code on rsp");

   // clear carries no geometry
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op == rrcm_pkg::OP_CLEAR |->
      rsp_native_x == 8'd0 && rsp_native_y == 8'd0 &&
      rsp_native_w == 8'd0 && rsp_native_h == 8'd0)
      else $error("clear with nonzero geometry");

   // a pixel is a single native cell, a rectangle is never empty
   a_sizes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op != rrcm_pkg::OP_CLEAR |->
      rsp_native_w != 8'd0 && rsp_native_h != 8'd0 &&
      (rsp_op != rrcm_pkg::OP_PIXEL || (rsp_native_w == 8'd1 && rsp_native_h == 8'd1)))
      else $error("bad native size on rsp");

endmodule

bind rotated_rect_clip_mapper_top rrcm_checker u_rrcm_checker (.*);

@@ tb/sv/tb_rotated_rect_clip_mapper_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotated_rect_clip_mapper_top
// Self-checking bench for the rotated rectangle clip mapper. Drawing
// commands go in over valid/ready under each of the four rotations. A local
// model of the clip and rotate math predicts the driver operation, if any,
// for each command without a typed result. Every returned operation is compared field by
// field against the oldest prediction. A short directed table of corner
// cases comes first. Randomized phases follow, with random idling on both
// sides and a long output hold that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_rotated_rect_clip_mapper_top;

   localparam int NW           = rrcm_pkg::NATIVE_WIDTH_DEF;
   localparam int NH           = rrcm_pkg::NATIVE_HEIGHT_DEF;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 40;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 121;
   localparam int CYCLE_LIMIT  = 100000;

   localparam logic [rrcm_pkg::CSR_ADDR_W-1:0] ADDR_ROTATION =
      {rrcm_pkg::REG_ROTATION, 2'b00};
   localparam logic [rrcm_pkg::CSR_ADDR_W-1:0] ADDR_SPARE    =
      {~rrcm_pkg::REG_ROTATION, 2'b00};

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] rect_w;
      logic [15:0] rect_h;
      logic [15:0] color;
   } draw_cmd_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  nx;
      logic [7:0]  ny;
      logic [7:0]  nw;
      logic [7:0]  nh;
      logic [15:0] color;
   } drv_op_type;

   // one line of the directed table; want/hit are used only when typed is set
   typedef struct packed {
      logic [1:0]   rot;
      draw_cmd_type c;
      logic         typed;
      logic         hit;
      drv_op_type   want;
   } corner_row_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [rrcm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [15:0] req_pos_x;
   logic [15:0] req_pos_y;
   logic [15:0] req_rect_w;
   logic [15:0] req_rect_h;
   logic [15:0] req_color;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_op;
   logic [7:0]  rsp_native_x;
   logic [7:0]  rsp_native_y;
   logic [7:0]  rsp_native_w;
   logic [7:0]  rsp_native_h;
   logic [15:0] rsp_out_color;

   drv_op_type     pending_ops[$];
   corner_row_type corner_rows[$];
   logic [1:0]     rotation_cfg = 2'd0;
   int             error_count  = 0;
   int             cycle_count  = 0;
   bit             send_idle    = 1'b1;
   bit             rsp_idle     = 1'b1;
   int             hold_asked   = 0;
   int             hold_served  = 0;
   int             stall_left   = 0;

   rotated_rect_clip_mapper_top uut (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_rect_w    (req_rect_w),
      .req_rect_h    (req_rect_h),
      .req_color     (req_color),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_op        (rsp_op),
      .rsp_native_x  (rsp_native_x),
      .rsp_native_y  (rsp_native_y),
      .rsp_native_w  (rsp_native_w),
      .rsp_native_h  (rsp_native_h),
      .rsp_out_color (rsp_out_color)
   );

   // 100 MHz clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t ERROR %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Prediction: clip in logical space, rotate both corners, reorder
   // ---------------------------------------------------------------------
   function automatic void to_native(input logic [1:0] rot, input int lx, input int ly,
                                     output int nx, output int ny);
      case (rot)
         2'd1: begin
            nx = NW - 1 - ly;
            ny = lx;
         end
         2'd2: begin
            nx = NW - 1 - lx;
            ny = NH - 1 - ly;
         end
         2'd3: begin
            nx = ly;
            ny = NH - 1 - lx;
         end
         default: begin
            nx = lx;
            ny = ly;
         end
      endcase
   endfunction

   function automatic bit predict_driver_op(input draw_cmd_type c, input logic [1:0] rot,
                                            output drv_op_type o);
      int x, y, w, h, lw, lh, ax, ay, bx, by, t;
      x  = int'($signed(c.pos_x));
      y  = int'($signed(c.pos_y));
      w  = int'($signed(c.rect_w));
      h  = int'($signed(c.rect_h));
      lw = rot[0] ? NH : NW;
      lh = rot[0] ? NW : NH;
      o       = '0;
      o.op    = c.cmd;
      o.color = c.color;
      case (c.cmd)
         rrcm_pkg::OP_PIXEL: begin
            if (x < 0 || y < 0 || x >= lw || y >= lh) return 1'b0;
            to_native(rot, x, y, ax, ay);
            o.nx = 8'(ax);
            o.ny = 8'(ay);
            o.nw = 8'd1;
            o.nh = 8'd1;
            return 1'b1;
         end
         rrcm_pkg::OP_CLEAR: return 1'b1;
         rrcm_pkg::OP_RECT: begin
            if (w <= 0 || h <= 0) return 1'b0;
            if (x < 0) begin
               w = w + x;
               x = 0;
            end
            if (y < 0) begin
               h = h + y;
               y = 0;
            end
            if (x >= lw || y >= lh) return 1'b0;
            if (x + w > lw) w = lw - x;
            if (y + h > lh) h = lh - y;
            if (w <= 0 || h <= 0) return 1'b0;
            to_native(rot, x, y, ax, ay);
            to_native(rot, x + w - 1, y + h - 1, bx, by);
            if (ax > bx) begin
               t  = ax;
               ax = bx;
               bx = t;
            end
            if (ay > by) begin
               t  = ay;
               ay = by;
               by = t;
            end
            o.nx = 8'(ax);
            o.ny = 8'(ay);
            o.nw = 8'(bx - ax + 1);
            o.nh = 8'(by - ay + 1);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : op_checker
      drv_op_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ops.size() == 0) begin
            report_error("driver op returned with none pending");
         end else begin
            want = pending_ops.pop_front();
            if (rsp_op !== want.op)
               report_error($sformatf("op: got %0d want %0d", rsp_op, want.op));
            if (rsp_native_x !== want.nx)
               report_error($sformatf("native_x: got %0d want %0d", rsp_native_x, want.nx));
            if (rsp_native_y !== want.ny)
               report_error($sformatf("native_y: got %0d want %0d", rsp_native_y, want.ny));
            if (rsp_native_w !== want.nw)
               report_error($sformatf("native_w: got %0d want %0d", rsp_native_w, want.nw));
            if (rsp_native_h !== want.nh)
               report_error($sformatf("native_h: got %0d want %0d", rsp_native_h, want.nh));
            if (rsp_out_color !== want.color)
               report_error($sformatf("color: got %h want %h", rsp_out_color, want.color));
         end
      end
   end

   // result sink: random back-pressure per transaction, plus long holds on request
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            stall_left  = LONG_HOLD;
         end else if (rsp_valid && rsp_ready) begin
            stall_left = rsp_idle ? int'($urandom_range(0, 3)) : 0;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Register access
   // ---------------------------------------------------------------------
   task automatic csr_access(input bit wr, input logic [rrcm_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // return to idle before the next access
      @(posedge clock);
   endtask

   task automatic check_rotation();
      logic [31:0] rd;
      csr_access(1'b0, ADDR_ROTATION, '0, rd);
      if (rd !== {30'd0, rotation_cfg})
         report_error($sformatf("rotation readback: got %h want %0d", rd, rotation_cfg));
   endtask

   // upper write bits are random; only the low two should stick
   task automatic set_rotation(input logic [1:0] rot);
      logic [31:0] wdata, rd;
      wdata      = $urandom;
      wdata[1:0] = rot;
      csr_access(1'b1, ADDR_ROTATION, wdata, rd);
      rotation_cfg = rot;
      check_rotation();
   endtask

   // drop valid, wait out every pending op, then let empty stages flush
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_ops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Command driver
   // ---------------------------------------------------------------------
   task automatic send_cmd(input draw_cmd_type c, input bit typed, input bit t_hit,
                           input drv_op_type t_want);
      int         gap;
      bit         hit;
      drv_op_type want;
      gap = send_idle ? int'($urandom_range(0, 3)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= c.cmd;
      req_pos_x  <= c.pos_x;
      req_pos_y  <= c.pos_y;
      req_rect_w <= c.rect_w;
      req_rect_h <= c.rect_h;
      req_color  <= c.color;
      do @(posedge clock); while (!req_ready);
      if (typed) begin
         hit  = t_hit;
         want = t_want;
      end else begin
         hit = predict_driver_op(c, rotation_cfg, want);
      end
      if (hit) pending_ops.push_back(want);
   endtask

   function automatic void add_row(input logic [1:0] rot, input logic [1:0] cmd,
                                   input int x, input int y, input int w, input int h,
                                   input int color, input bit typed = 1'b0,
                                   input bit hit = 1'b0, input int nx = 0,
                                   input int ny = 0, input int nw = 0, input int nh = 0);
      corner_row_type r;
      r            = '0;
      r.rot        = rot;
      r.c.cmd      = cmd;
      r.c.pos_x    = x[15:0];
      r.c.pos_y    = y[15:0];
      r.c.rect_w   = w[15:0];
      r.c.rect_h   = h[15:0];
      r.c.color    = color[15:0];
      r.typed      = typed;
      r.hit        = hit;
      r.want.op    = cmd;
      r.want.nx    = nx[7:0];
      r.want.ny    = ny[7:0];
      r.want.nw    = nw[7:0];
      r.want.nh    = nh[7:0];
      r.want.color = color[15:0];
      corner_rows.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Random commands: mostly near the screen, some far out, some raw
   // ---------------------------------------------------------------------
   function automatic logic [15:0] random_coord(input int span);
      int v;
      case ($urandom_range(0, 9))
         0, 1:    v = $urandom;
         2:       v = int'($urandom_range(0, 600)) - 300;
         default: v = int'($urandom_range(0, span + 15)) - 8;
      endcase
      return v[15:0];
   endfunction

   function automatic logic [15:0] random_extent(input int span);
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom;
         1:       v = int'($urandom_range(0, 4)) - 2;
         2, 3:    v = int'($urandom_range(0, 2 * span));
         default: v = int'($urandom_range(1, span / 2 + 1));
      endcase
      return v[15:0];
   endfunction

   function automatic draw_cmd_type random_cmd(input logic [1:0] rot);
      draw_cmd_type c;
      int           lw, lh, pick;
      lw   = rot[0] ? NH : NW;
      lh   = rot[0] ? NW : NH;
      pick = $urandom_range(0, 19);
      if (pick < 8)       c.cmd = rrcm_pkg::OP_PIXEL;
      else if (pick < 17) c.cmd = rrcm_pkg::OP_RECT;
      else if (pick < 19) c.cmd = rrcm_pkg::OP_CLEAR;
      else                c.cmd = rrcm_pkg::OP_UNUSED;
      c.pos_x  = random_coord(lw);
      c.pos_y  = random_coord(lh);
      c.rect_w = random_extent(lw);
      c.rect_h = random_extent(lh);
      c.color  = 16'($urandom);
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] rd;
      logic [1:0]  rot;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_valid   = 1'b0;
      req_cmd     = rrcm_pkg::OP_PIXEL;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_rect_w  = '0;
      req_rect_h  = '0;
      req_color   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rotation comes out of reset at zero; a write to the unmapped slot is dropped
      check_rotation();
      csr_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF, rd);
      check_rotation();

      // on-screen and off-screen pixels, with extreme coordinates
      add_row(0, rrcm_pkg::OP_PIXEL, 0, 0, -32768, 32767, 'h0000, 1, 1, 0, 0, 1, 1);
      add_row(0, rrcm_pkg::OP_PIXEL, 95, 63, 0, 0, 'hFFFF, 1, 1, 95, 63, 1, 1);
      add_row(0, rrcm_pkg::OP_PIXEL, 96, 0, 1, 1, 'h1234, 1, 0);
      add_row(0, rrcm_pkg::OP_PIXEL, -1, 0, 1, 1, 'h1234, 1, 0);
      add_row(0, rrcm_pkg::OP_PIXEL, 0, 64, 1, 1, 'h1234, 1, 0);
      add_row(0, rrcm_pkg::OP_PIXEL, -32768, 32767, 1, 1, 'h5555, 1, 0);
      // clear ignores position and size
      add_row(0, rrcm_pkg::OP_CLEAR, 32767, -32768, 5, 5, 'hA5A5, 1, 1, 0, 0, 0, 0);
      // full screen, empty, clipped and clipped-away rectangles
      add_row(0, rrcm_pkg::OP_RECT, 0, 0, 96, 64, 'h0001, 1, 1, 0, 0, 96, 64);
      add_row(0, rrcm_pkg::OP_RECT, -32768, -32768, 32767, 32767, 'h0002, 1, 0);
      add_row(0, rrcm_pkg::OP_RECT, 10, 10, 0, 5, 'h0003, 1, 0);
      add_row(0, rrcm_pkg::OP_RECT, 10, 10, 5, -32768, 'h0004, 1, 0);
      add_row(0, rrcm_pkg::OP_RECT, -5, -5, 10, 10, 'h0005, 1, 1, 0, 0, 5, 5);
      add_row(0, rrcm_pkg::OP_RECT, 90, 60, 32767, 32767, 'h0006, 1, 1, 90, 60, 6, 4);
      add_row(0, rrcm_pkg::OP_RECT, 96, 0, 5, 5, 'h0007, 1, 0);
      add_row(0, rrcm_pkg::OP_RECT, -10, 0, 10, 5, 'h0008, 1, 0);
      add_row(0, rrcm_pkg::OP_RECT, 32767, 32767, 32767, 32767, 'h0009, 1, 0);
      // the spare command code is swallowed
      add_row(0, rrcm_pkg::OP_UNUSED, 1, 1, 2, 2, 'h000A, 1, 0);
      // the other rotations go through the model
      add_row(1, rrcm_pkg::OP_PIXEL, 0, 0, 1, 1, 'h1111);
      add_row(1, rrcm_pkg::OP_PIXEL, 63, 95, 1, 1, 'h2222);
      add_row(1, rrcm_pkg::OP_PIXEL, 64, 0, 1, 1, 'h3333);
      add_row(1, rrcm_pkg::OP_RECT, -3, -3, 20, 30, 'h4444);
      add_row(2, rrcm_pkg::OP_PIXEL, 0, 0, 1, 1, 'h5555);
      add_row(2, rrcm_pkg::OP_RECT, 5, 5, 10, 10, 'h6666);
      add_row(3, rrcm_pkg::OP_RECT, 0, 0, 64, 96, 'h7777);
      add_row(3, rrcm_pkg::OP_PIXEL, 63, 95, 1, 1, 'h8888);

      foreach (corner_rows[i]) begin
         if (corner_rows[i].rot != rotation_cfg) begin
            settle();
            set_rotation(corner_rows[i].rot);
         end
         send_cmd(corner_rows[i].c, corner_rows[i].typed, corner_rows[i].hit,
                  corner_rows[i].want);
      end

      // random phases, one rotation each; some without idling, two with a long hold
      for (int p = 0; p < PHASES; p++) begin
         settle();
         rot = (p < 8) ? 2'(p % 4) : 2'($urandom_range(0, 3));
         set_rotation(rot);
         send_idle = (p % 3 != 2);
         if (p == 4 || p == 9) begin
            send_idle = 1'b0;
            hold_asked <= hold_asked + 1;
         end
         rsp_idle <= send_idle;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_cmd(random_cmd(rotation_cfg), 1'b0, 1'b0, '0);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
